// ===== hdl/mwe_pkg.sv =====
// Shared constants, types and weight tables for the modulating window estimator.
`default_nettype none

package mwe_pkg;

  localparam int WINDOW_LENGTH   = 64;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int GAIN_WIDTH      = 16;
  localparam int WEIGHT_WIDTH    = 18;
  localparam int OUT_WIDTH       = 32;
  localparam int IDX_WIDTH       = $clog2(WINDOW_LENGTH);
  localparam int PROD_WIDTH      = WEIGHT_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_WIDTH       = PROD_WIDTH + IDX_WIDTH;
  localparam int GPROD_WIDTH     = GAIN_WIDTH + ACC_WIDTH;
  localparam int TOTAL_WIDTH     = ACC_WIDTH + 10;
  localparam int TDATA_IN_WIDTH  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int TDATA_OUT_WIDTH = ((OUT_WIDTH + 7) / 8) * 8;
  localparam int CFG_ADDR_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  // Register index taken from paddr above the byte offset.
  localparam logic [CFG_ADDR_WIDTH-3:0] REG_GAIN = '0;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(4096);

  // Rounding bias for the final shift from Q20 to Q8.
  localparam int ROUND_SHIFT = 12;
  localparam logic signed [TOTAL_WIDTH-1:0] ROUND_BIAS = TOTAL_WIDTH'(2048);

  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAP,
    S_DRAIN,
    S_GAIN,
    S_SUM,
    S_FIN
  } state_t;

  typedef logic signed [WEIGHT_WIDTH-1:0] weight_tab_t [WINDOW_LENGTH];

  localparam longint WL   = WINDOW_LENGTH;
  localparam longint WL3  = WL * WL * WL;
  localparam longint WL5  = WL3 * WL * WL;
  localparam longint WMAX = (64'sd1 <<< (WEIGHT_WIDTH - 1)) - 1;
  localparam longint WMIN = -(64'sd1 <<< (WEIGHT_WIDTH - 1));

  function automatic longint sat_weight(longint v);
    if (v > WMAX) begin
      return WMAX;
    end else if (v < WMIN) begin
      return WMIN;
    end
    return v;
  endfunction

  // Plant weights: 60/N * (1 - 6x + 6x^2) in Q2.16, rounded half away from zero.
  function automatic weight_tab_t plant_weights();
    weight_tab_t tab;
    longint kk;
    longint p;
    longint ap;
    longint q;
    for (int k = 0; k < WINDOW_LENGTH; k++) begin
      kk = k;
      p  = WL * WL - 6 * kk * WL + 6 * kk * kk;
      ap = (p < 0) ? -p : p;
      q  = (2 * 60 * 65536 * ap + WL3) / (2 * WL3);
      tab[k] = WEIGHT_WIDTH'(sat_weight((p < 0) ? -q : q));
      if (k == 0 || k == WINDOW_LENGTH - 1) begin
        tab[k] = '0;
      end
    end
    return tab;
  endfunction

  // Estimator weights: 30/N * (1 - x)^2 * x^2 in Q2.16.
  function automatic weight_tab_t est_weights();
    weight_tab_t tab;
    longint kk;
    longint r;
    longint q;
    for (int k = 0; k < WINDOW_LENGTH; k++) begin
      kk = k;
      r  = (WL - kk) * kk;
      q  = (2 * 30 * 65536 * r * r + WL5) / (2 * WL5);
      tab[k] = WEIGHT_WIDTH'(sat_weight(q));
      if (k == 0 || k == WINDOW_LENGTH - 1) begin
        tab[k] = '0;
      end
    end
    return tab;
  endfunction

  localparam weight_tab_t PLANT_W = plant_weights();
  localparam weight_tab_t EST_W   = est_weights();

  // Ring index step with wrap at the window length.
  function automatic logic [IDX_WIDTH-1:0] idx_inc(logic [IDX_WIDTH-1:0] a);
    if (a == IDX_WIDTH'(WINDOW_LENGTH - 1)) begin
      return '0;
    end
    return a + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/modulating_window_estimator.sv =====
// Top level of the modulating window estimator: sample ring, dual MAC sequencer, output stage.
// One word is in progress at a time; the next is taken only once the result is loaded into the
// output register. Each word makes one pass of the plant/estimator MAC pair over the interior
// taps, one ring read per cycle. Synchronous reset sets gain to 1.0 and marks every ring
// entry empty, so the windows read as zero at once; there is no clearing pass. The output
// register frees the next input.
`default_nettype none

module modulating_window_estimator (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mwe_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
  input  logic [mwe_pkg::CFG_DATA_WIDTH-1:0]   pwdata,
  output logic [mwe_pkg::CFG_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata, low to high: plant_sample, estimator_sample
  input  logic [mwe_pkg::TDATA_IN_WIDTH-1:0]   s_tdata,
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata, low to high: estimate
  output logic [mwe_pkg::TDATA_OUT_WIDTH-1:0]  m_tdata
);

  import mwe_pkg::*;

  state_t state;
  state_t state_next;

  logic signed [GAIN_WIDTH-1:0]   gain;
  logic [IDX_WIDTH-1:0]           pos;
  logic [IDX_WIDTH-1:0]           rd_addr;
  logic [IDX_WIDTH-1:0]           tap;
  logic [WINDOW_LENGTH-1:0]       vld;

  logic                           s1_vld;
  logic                           s1_hit;
  logic [IDX_WIDTH-1:0]           s1_tap;
  logic                           s2_vld;

  logic [2*SAMPLE_WIDTH-1:0]      ram_rdata;
  logic signed [SAMPLE_WIDTH-1:0] psamp;
  logic signed [SAMPLE_WIDTH-1:0] esamp;
  logic signed [PROD_WIDTH-1:0]   pprod;
  logic signed [PROD_WIDTH-1:0]   eprod;
  logic signed [ACC_WIDTH-1:0]    psum;
  logic signed [ACC_WIDTH-1:0]    esum;
  logic signed [GPROD_WIDTH-1:0]  gprod;
  logic signed [TOTAL_WIDTH-1:0]  total;
  logic signed [TOTAL_WIDTH-1:0]  shifted;
  logic [TOTAL_WIDTH-OUT_WIDTH:0] top_bits;
  logic [OUT_WIDTH-1:0]           sat_out;

  logic                           s_acc;
  logic                           out_load;
  logic                           cfg_wr;
  logic [CFG_ADDR_WIDTH-3:0]      reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_WIDTH-1:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = (reg_idx == REG_GAIN) ? CFG_DATA_WIDTH'(gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_wr && reg_idx == REG_GAIN) begin
      gain <= pwdata[GAIN_WIDTH-1:0];
    end
  end

  // Sample ring: both samples of one word share one entry.
  mwe_ram #(
    .WIDTH (2 * SAMPLE_WIDTH),
    .DEPTH (WINDOW_LENGTH)
  ) u_ram (
    .clk   (clk),
    .we    (s_acc),
    .waddr (pos),
    .wdata (s_tdata[2*SAMPLE_WIDTH-1:0]),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_TAP;
        end
      end
      S_TAP: begin
        if (tap == IDX_WIDTH'(WINDOW_LENGTH - 2)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_vld && !s2_vld) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign s_acc = s_tvalid & s_tready;

  // Ring pointers, valid bits and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      vld    <= '0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= (state == S_TAP);
      s2_vld <= s1_vld;
      if (s_acc) begin
        pos      <= idx_inc(pos);
        vld[pos] <= 1'b1;
      end
    end
  end

  // The oldest sample sits one past the write slot; tap 1 is one further.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_addr <= idx_inc(idx_inc(pos));
      tap     <= IDX_WIDTH'(1);
    end else if (state == S_TAP) begin
      rd_addr <= idx_inc(rd_addr);
      tap     <= tap + 1'b1;
    end
    s1_tap <= tap;
    s1_hit <= vld[rd_addr];
  end

  // An entry never written reads as zero.
  assign psamp = s1_hit ? ram_rdata[SAMPLE_WIDTH-1:0] : '0;
  assign esamp = s1_hit ? ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;

  // MAC pair, then the gain product and the final rounding sum.
  always_ff @(posedge clk) begin
    pprod <= PLANT_W[s1_tap] * psamp;
    eprod <= EST_W[s1_tap] * esamp;
    if (s_acc) begin
      psum <= '0;
      esum <= '0;
    end else if (s2_vld) begin
      psum <= psum + ACC_WIDTH'(pprod);
      esum <= esum + ACC_WIDTH'(eprod);
    end
    if (state == S_GAIN) begin
      gprod <= gain * esum;
    end
    if (state == S_SUM) begin
      total <= (TOTAL_WIDTH'(psum) <<< 4) + TOTAL_WIDTH'(gprod >>> 8) + ROUND_BIAS;
    end
  end

  assign shifted  = total >>> ROUND_SHIFT;
  assign top_bits = shifted[TOTAL_WIDTH-1:OUT_WIDTH-1];

  always_comb begin
    if (&top_bits || ~|top_bits) begin
      sat_out = shifted[OUT_WIDTH-1:0];
    end else if (shifted[TOTAL_WIDTH-1]) begin
      sat_out = OUT_MIN;
    end else begin
      sat_out = OUT_MAX;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= TDATA_OUT_WIDTH'(sat_out);
    end
  end

  // Checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in progress");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_GAIN |-> !s1_vld && !s2_vld)
    else $error("gain product started before the MAC pipeline drained");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TAP |-> tap != '0 && tap <= IDX_WIDTH'(WINDOW_LENGTH - 2))
    else $error("tap counter left the interior range");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_FIN)
    else $error("result word raised outside the final step");

endmodule

`default_nettype wire

// ===== hdl/mwe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mwe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
